>>> src/trie_insert_search_unit_macros.svh
// assertion macros for the trie insert/search unit
`ifndef TRIE_INSERT_SEARCH_UNIT_MACROS_SVH
`define TRIE_INSERT_SEARCH_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define TIS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TIS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/tis_pkg.sv
// shared types and constants of the trie insert/search unit
`timescale 1ns / 1ps
`default_nettype none

package tis_pkg;

    localparam logic       OP_INSERT    = 1'b0;
    localparam logic       OP_SEARCH    = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_BADCHAR   = 2'd2;

    localparam logic [7:0] FIRST_LETTER = 8'd65;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LINK,
        S_TERM,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic link_rd;
        logic link_wr;
        logic term_rd;
        logic term_wr;
    } t_store_cmd;

endpackage

`default_nettype wire

>>> src/tis_node_store.sv
// node pool memories: child links and terminal marks, with clearing pass after reset
`timescale 1ns / 1ps
`default_nettype none

module tis_node_store #(
    parameter int NODE_COUNT    = 1024,
    parameter int ALPHABET_SIZE = 26
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire tis_pkg::t_store_cmd                       i_cmd,
    input  wire logic [$clog2(NODE_COUNT*ALPHABET_SIZE)-1:0] i_link_addr,
    input  wire logic [$clog2(NODE_COUNT)-1:0]             i_link_wdata,
    input  wire logic [$clog2(NODE_COUNT)-1:0]             i_term_addr,
    output logic      [$clog2(NODE_COUNT)-1:0]             o_link_rdata,
    output logic                                           o_term_rdata,
    output logic                                           o_busy
);

    localparam int DEPTH = NODE_COUNT * ALPHABET_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(NODE_COUNT);

    logic [NW-1:0] r_link_mem [DEPTH];
    logic          r_term_mem [NODE_COUNT];

    logic [AW-1:0] r_clr_addr;
    logic          r_busy;
    logic [NW-1:0] r_link_rdata;
    logic          r_term_rdata;

    // clearing sweep, one link entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_busy     <= 1'b1;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_link_mem[r_clr_addr] <= '0;
        end else if (i_cmd.link_wr) begin
            r_link_mem[i_link_addr] <= i_link_wdata;
        end
        if (i_cmd.link_rd) begin
            r_link_rdata <= r_link_mem[i_link_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            if (r_clr_addr < AW'(NODE_COUNT)) begin
                r_term_mem[r_clr_addr[NW-1:0]] <= 1'b0;
            end
        end else if (i_cmd.term_wr) begin
            r_term_mem[i_term_addr] <= 1'b1;
        end
        if (i_cmd.term_rd) begin
            r_term_rdata <= r_term_mem[i_term_addr];
        end
    end

    assign o_link_rdata = r_link_rdata;
    assign o_term_rdata = r_term_rdata;
    assign o_busy       = r_busy;

endmodule

`default_nettype wire

>>> src/trie_insert_search_unit.sv
// trie insert/search unit: word walker over a node pool memory
// a letter item that walks the trie does a child link read, then an allocate/update
// a final search item that has not failed also does a terminal read
// the result word is registered; while the output stalls it is held pending in S_HOLD
// after reset the link and terminal memories are swept, and the input stays stalled
// in S_CLEAR until the sweep is done
`timescale 1ns / 1ps
`default_nettype none

`include "trie_insert_search_unit_macros.svh"

module trie_insert_search_unit #(
    parameter int NODE_COUNT    = 1024,
    parameter int ALPHABET_SIZE = 26
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_opcode,
    input  wire logic [7:0] i_letter,
    input  wire logic       i_no_letter,
    input  wire logic       i_is_last,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_found,
    output logic      [1:0] o_status
);

    localparam int AW  = $clog2(NODE_COUNT * ALPHABET_SIZE);
    localparam int NW  = $clog2(NODE_COUNT);
    localparam int NFW = $clog2(NODE_COUNT + 1);
    localparam int IW  = $clog2(ALPHABET_SIZE);

    tis_pkg::t_state     r_state, n_state;
    logic [NW-1:0]       r_cursor, n_cursor;
    logic [NFW-1:0]      r_next_free, n_next_free;
    logic                r_failed, n_failed;
    logic [1:0]          r_status, n_status;
    logic                r_opcode, n_opcode;
    logic                r_last, n_last;
    logic [AW-1:0]       r_link_addr, n_link_addr;
    logic                r_out_valid, n_out_valid;
    logic                r_found, n_found;
    logic [1:0]          r_out_status, n_out_status;
    logic                r_pend_found, n_pend_found;
    logic [1:0]          r_pend_status, n_pend_status;

    tis_pkg::t_store_cmd cmd;
    logic [AW-1:0]       link_addr;
    logic [NW-1:0]       term_addr;
    logic [NW-1:0]       link_rdata;
    logic                term_rdata;
    logic                store_busy;

    logic [8:0]          letter_diff;
    logic                letter_ok;
    logic [IW-1:0]       letter_idx;
    logic                accept;
    logic                out_free;
    logic                fin;
    logic                fin_found;
    logic [1:0]          fin_status;

    tis_node_store #(
        .NODE_COUNT   (NODE_COUNT),
        .ALPHABET_SIZE(ALPHABET_SIZE)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_link_addr (link_addr),
        .i_link_wdata(r_next_free[NW-1:0]),
        .i_term_addr (term_addr),
        .o_link_rdata(link_rdata),
        .o_term_rdata(term_rdata),
        .o_busy      (store_busy)
    );

    assign letter_diff = {1'b0, i_letter} - {1'b0, tis_pkg::FIRST_LETTER};
    assign letter_ok   = (i_letter >= tis_pkg::FIRST_LETTER) &&
                         (letter_diff < 9'(ALPHABET_SIZE));
    assign letter_idx  = letter_diff[IW-1:0];
    assign o_in_stall  = (r_state != tis_pkg::S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tis_pkg::S_CLEAR;
            r_cursor    <= '0;
            r_next_free <= NFW'(1);
            r_failed    <= 1'b0;
            r_status    <= tis_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_next_free <= n_next_free;
            r_failed    <= n_failed;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opcode      <= n_opcode;
        r_last        <= n_last;
        r_link_addr   <= n_link_addr;
        r_found       <= n_found;
        r_out_status  <= n_out_status;
        r_pend_found  <= n_pend_found;
        r_pend_status <= n_pend_status;
    end

    always_comb begin
        n_state       = r_state;
        n_cursor      = r_cursor;
        n_next_free   = r_next_free;
        n_failed      = r_failed;
        n_status      = r_status;
        n_opcode      = r_opcode;
        n_last        = r_last;
        n_link_addr   = r_link_addr;
        n_out_valid   = r_out_valid && i_out_stall;
        n_found       = r_found;
        n_out_status  = r_out_status;
        n_pend_found  = r_pend_found;
        n_pend_status = r_pend_status;
        cmd           = '0;
        link_addr     = r_link_addr;
        term_addr     = r_cursor;
        fin           = 1'b0;
        fin_found     = 1'b0;
        fin_status    = tis_pkg::ST_OK;

        case (r_state)
            tis_pkg::S_CLEAR: begin
                if (!store_busy) begin
                    n_state = tis_pkg::S_IDLE;
                end
            end
            tis_pkg::S_IDLE: begin
                if (accept) begin
                    n_opcode = i_opcode;
                    n_last   = i_is_last;
                    if (!i_no_letter && !letter_ok) begin
                        n_failed = 1'b1;
                        if (r_status == tis_pkg::ST_OK) begin
                            n_status = tis_pkg::ST_BADCHAR;
                        end
                    end
                    if (!i_no_letter && letter_ok && !r_failed) begin
                        n_link_addr  = AW'(r_cursor) * AW'(ALPHABET_SIZE) + AW'(letter_idx);
                        link_addr    = n_link_addr;
                        cmd.link_rd  = 1'b1;
                        n_state      = tis_pkg::S_LINK;
                    end else if (i_is_last) begin
                        if (!n_failed && i_opcode == tis_pkg::OP_SEARCH) begin
                            cmd.term_rd = 1'b1;
                            n_state     = tis_pkg::S_TERM;
                        end else begin
                            cmd.term_wr = !n_failed;
                            fin         = 1'b1;
                            fin_status  = n_status;
                        end
                    end
                end
            end
            tis_pkg::S_LINK: begin
                if (link_rdata != '0) begin
                    n_cursor = link_rdata;
                end else if (r_opcode == tis_pkg::OP_SEARCH) begin
                    n_failed = 1'b1;
                end else if (r_next_free == NFW'(NODE_COUNT)) begin
                    n_failed = 1'b1;
                    n_status = tis_pkg::ST_FULL;
                end else begin
                    cmd.link_wr = 1'b1;
                    n_cursor    = r_next_free[NW-1:0];
                    n_next_free = r_next_free + NFW'(1);
                end
                term_addr = n_cursor;
                if (!r_last) begin
                    n_state = tis_pkg::S_IDLE;
                end else if (!n_failed && r_opcode == tis_pkg::OP_SEARCH) begin
                    cmd.term_rd = 1'b1;
                    n_state     = tis_pkg::S_TERM;
                end else begin
                    cmd.term_wr = !n_failed;
                    fin         = 1'b1;
                    fin_status  = n_status;
                end
            end
            tis_pkg::S_TERM: begin
                fin        = 1'b1;
                fin_found  = term_rdata;
                fin_status = r_status;
            end
            tis_pkg::S_HOLD: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_found      = r_pend_found;
                    n_out_status = r_pend_status;
                    n_state      = tis_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tis_pkg::S_IDLE;
            end
        endcase

        // end of word: hand over the result word, or park it in S_HOLD while the output stalls, and rewind to the root
        if (fin) begin
            if (out_free) begin
                n_out_valid  = 1'b1;
                n_found      = fin_found;
                n_out_status = fin_status;
                n_state      = tis_pkg::S_IDLE;
            end else begin
                n_pend_found  = fin_found;
                n_pend_status = fin_status;
                n_state       = tis_pkg::S_HOLD;
            end
            n_cursor = '0;
            n_failed = 1'b0;
            n_status = tis_pkg::ST_OK;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_status    = r_out_status;

    `TIS_ASSERT_NOW(a_pool_bound, 1'b1, r_next_free <= NFW'(NODE_COUNT), "pool count past end")
    `TIS_ASSERT_NOW(a_cursor_alloc, 1'b1, NFW'(r_cursor) < r_next_free, "cursor on free node")
    `TIS_ASSERT_NOW(a_link_wr_absent, cmd.link_wr, link_rdata == '0, "overwrite of live link")
    `TIS_ASSERT_NOW(a_no_accept_clear, store_busy, o_in_stall, "word taken during clear")
    `TIS_ASSERT_NEXT(a_alloc, cmd.link_wr, r_next_free == $past(r_next_free) + NFW'(1), "no alloc")

endmodule

`default_nettype wire
